// File: rtl/multi_body_displacement_blend_top_assert.svh
// Assertion macros used by the displacement blend back end.
`ifndef MULTI_BODY_DISPLACEMENT_BLEND_TOP_ASSERT_SVH
`define MULTI_BODY_DISPLACEMENT_BLEND_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MBDB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbdb same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MBDB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbdb next-cycle check failed");

`endif

// File: rtl/mbdb_pkg.sv
// Package with shared constants and types of the displacement blend.
`timescale 1ns / 1ps
package mbdb_pkg;
	localparam int MAX_BODIES_DEF = 16;
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_SMALL_OFFSET = 2'd0;
	localparam logic [7:0] SMALL_OFFSET_RST = 8'd1;
	localparam logic [36:0] RSUM_ONE = 37'd65536;

	// One body item after the ratio has been formed.
	typedef struct packed {
		logic [31:0]        ratio;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic               last;
	} item_t;
endpackage

// File: rtl/multi_body_displacement_blend_top.sv
// Front: each body item goes through the 32-step ratio divider, then is pushed.
// A last body item adds four 68-step divisions in the back before its result.
// No new body item is taken until the last one is pushed; a full queue holds it.
// Reset: asynchronous, active low; small_offset returns to 1 and the sums to their start.
// Top level of the multi-body displacement blend with its APB register.
`timescale 1ns / 1ps
module multi_body_displacement_blend_top #(
	parameter int MAX_BODIES = mbdb_pkg::MAX_BODIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mbdb_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [15:0]                  body_weight,
	input  logic signed [31:0]           disp_x,
	input  logic signed [31:0]           disp_y,
	input  logic signed [31:0]           disp_z,
	input  logic                         last_body,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [31:0]           out_x,
	output logic signed [31:0]           out_y,
	output logic signed [31:0]           out_z,
	output logic [15:0]                  far_field_weight
);
	logic [7:0]      small_q;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;
	mbdb_pkg::item_t wr_item;
	mbdb_pkg::item_t rd_item;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_q <= mbdb_pkg::SMALL_OFFSET_RST;
		end else if (psel && penable && pwrite && (paddr == mbdb_pkg::ADDR_SMALL_OFFSET)) begin
			small_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == mbdb_pkg::ADDR_SMALL_OFFSET) ? {24'd0, small_q} : 32'd0;

	mbdb_front #(.MAX_BODIES(MAX_BODIES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.small_offset (small_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.body_weight  (body_weight),
		.disp_x       (disp_x),
		.disp_y       (disp_y),
		.disp_z       (disp_z),
		.last_body    (last_body),
		.push         (push),
		.item         (wr_item),
		.full         (full)
	);

	mbdb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_item),
		.full   (full),
		.pop    (pop),
		.rdata  (rd_item),
		.empty  (empty)
	);

	mbdb_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.empty            (empty),
		.head             (rd_item),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_x            (out_x),
		.out_y            (out_y),
		.out_z            (out_z),
		.far_field_weight (far_field_weight)
	);
endmodule

// File: rtl/mbdb_div.sv
// Restoring long divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module mbdb_div #(
	parameter int N = 32,
	parameter int M = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [M-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quot
);
	localparam int CW = $clog2(N + 1);

	logic [CW-1:0] cnt_q;
	logic [M-1:0]  rem_q;
	logic [N-1:0]  q_q;
	logic [M-1:0]  div_q;
	logic          done_q;
	logic [M:0]    trial;
	logic          fits;

	// Shift in the next dividend bit and try a subtraction.
	assign trial = {rem_q, q_q[N-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(N);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? M'(trial - {1'b0, div_q}) : trial[M-1:0];
			q_q   <= {q_q[N-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule

// File: rtl/mbdb_fifo.sv
// Two-entry queue between the ratio front end and the accumulating back end.
`timescale 1ns / 1ps
module mbdb_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mbdb_pkg::item_t    wdata,
	output logic               full,
	input  logic               pop,
	output mbdb_pkg::item_t    rdata,
	output logic               empty
);
	mbdb_pkg::item_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	assign rdata = mem_q[rp_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
endmodule

// File: rtl/mbdb_front.sv
// Front end: accepts body items, counts bodies and forms the weight ratio.
`timescale 1ns / 1ps
module mbdb_front #(
	parameter int MAX_BODIES = mbdb_pkg::MAX_BODIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         small_offset,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        body_weight,
	input  logic signed [31:0] disp_x,
	input  logic signed [31:0] disp_y,
	input  logic signed [31:0] disp_z,
	input  logic               last_body,
	output logic               push,
	output mbdb_pkg::item_t    item,
	input  logic               full
);
	localparam int CNT_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
	localparam logic [1:0] ST_IDLE = 2'd0, ST_DIV = 2'd1, ST_PUSH = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	mbdb_pkg::item_t  item_q;
	logic             accept;
	logic             last_eff;
	logic             div_done;
	logic [31:0]      quot;
	logic [16:0]      denom;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign last_eff = last_body || (cnt_q == CNT_W'(MAX_BODIES - 1));
	assign denom    = 17'd65536 + {9'd0, small_offset} - {1'b0, body_weight};

	mbdb_div #(.N(32), .M(17)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend ({body_weight, 16'd0}),
		.divisor  (denom),
		.done     (div_done),
		.quot     (quot)
	);

	// Item sequencing and body count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						cnt_q   <= last_eff ? '0 : cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Captured item payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.dx   <= disp_x;
			item_q.dy   <= disp_y;
			item_q.dz   <= disp_z;
			item_q.last <= last_eff;
		end
		if (div_done) begin
			item_q.ratio <= quot;
		end
	end

	assign push = (state_q == ST_PUSH) && !full;
	assign item = item_q;
endmodule

// File: rtl/mbdb_back.sv
// Back end: accumulates ratio and scaled vectors, then divides out the blend.
`timescale 1ns / 1ps
`include "multi_body_displacement_blend_top_assert.svh"
module mbdb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  mbdb_pkg::item_t    head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [15:0]        far_field_weight
);
	localparam logic [1:0] ST_IDLE = 2'd0, ST_MUL = 2'd1, ST_DIV = 2'd2, ST_FIN = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         ph_q;
	mbdb_pkg::item_t    cur_q;
	logic [36:0]        rsum_q;
	logic signed [51:0] vsum_q [3];
	logic signed [64:0] prod_q;
	logic [31:0]        res_q [4];
	logic               out_valid_q;
	logic signed [31:0] d_sel;
	logic [37:0]        rsum_add;
	logic signed [48:0] term;
	logic signed [52:0] vsum_add;
	logic [1:0]         acc_idx;
	logic [1:0]         div_idx;
	logic               div_start;
	logic               div_done;
	logic [67:0]        quot;
	logic [67:0]        dividend;
	logic [51:0]        mag;
	logic               neg;
	logic [31:0]        res_val;
	logic               fin_go;

	// Component select for the multiplier.
	always_comb begin
		case (ph_q)
			2'd0:    d_sel = cur_q.dx;
			2'd1:    d_sel = cur_q.dy;
			default: d_sel = cur_q.dz;
		endcase
	end

	// Accumulation arithmetic; the shift floors toward minus infinity.
	assign acc_idx  = ph_q - 2'd1;
	assign rsum_add = {1'b0, rsum_q} + {6'd0, cur_q.ratio};
	assign term     = prod_q[64:16];
	assign vsum_add = {vsum_q[acc_idx][51], vsum_q[acc_idx]} + {{4{term[48]}}, term};

	// Division operand for the next component; the last one is the far field.
	assign div_idx   = (state_q == ST_MUL) ? 2'd0 : ph_q + 2'd1;
	assign div_start = ((state_q == ST_MUL) && (ph_q == 2'd3) && cur_q.last)
		|| ((state_q == ST_DIV) && div_done && (ph_q != 2'd3));
	assign mag = vsum_q[div_idx][51] ? 52'(-vsum_q[div_idx]) : 52'(vsum_q[div_idx]);
	assign dividend = (div_idx == 2'd3) ? (68'd1 << 32) : {mag, 16'd0};

	mbdb_div #(.N(68), .M(37)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (rsum_q),
		.done     (div_done),
		.quot     (quot)
	);

	// Saturate and sign the finished quotient.
	assign neg = vsum_q[ph_q][51];
	always_comb begin
		if (ph_q == 2'd3) begin
			res_val = (quot >= 68'hFFFF) ? 32'h0000FFFF : {16'd0, quot[15:0]};
		end else if (neg) begin
			res_val = (quot > 68'h80000000) ? 32'h80000000 : 32'(-quot[31:0]);
		end else begin
			res_val = (quot > 68'h7FFFFFFF) ? 32'h7FFFFFFF : quot[31:0];
		end
	end

	assign pop    = (state_q == ST_IDLE) && !empty;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Control and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
			rsum_q      <= mbdb_pkg::RSUM_ONE;
			vsum_q[0]   <= '0;
			vsum_q[1]   <= '0;
			vsum_q[2]   <= '0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MUL;
						ph_q    <= '0;
					end
				end
				ST_MUL: begin
					if (ph_q == 2'd0) begin
						rsum_q <= rsum_add[37] ? '1 : rsum_add[36:0];
					end else begin
						if (vsum_add[52] != vsum_add[51]) begin
							vsum_q[acc_idx] <= vsum_add[52] ? {1'b1, 51'd0} : {1'b0, {51{1'b1}}};
						end else begin
							vsum_q[acc_idx] <= vsum_add[51:0];
						end
					end
					if (ph_q == 2'd3) begin
						ph_q    <= '0;
						state_q <= cur_q.last ? ST_DIV : ST_IDLE;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (ph_q == 2'd3) begin
							state_q <= ST_FIN;
						end else begin
							ph_q <= ph_q + 2'd1;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q   <= ST_IDLE;
						rsum_q    <= mbdb_pkg::RSUM_ONE;
						vsum_q[0] <= '0;
						vsum_q[1] <= '0;
						vsum_q[2] <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if ((state_q == ST_MUL) && (ph_q != 2'd3)) begin
			prod_q <= $signed({1'b0, cur_q.ratio}) * d_sel;
		end
		if ((state_q == ST_DIV) && div_done) begin
			res_q[ph_q] <= res_val;
		end
		if (fin_go) begin
			out_x            <= res_q[0];
			out_y            <= res_q[1];
			out_z            <= res_q[2];
			far_field_weight <= res_q[3][15:0];
		end
	end

	assign out_valid = out_valid_q;

	`MBDB_ASSERT_IMP(a_done_in_div, div_done, state_q == ST_DIV)
	`MBDB_ASSERT_IMP(a_pop_idle, pop, (state_q == ST_IDLE) && !empty)
	`MBDB_ASSERT_NXT(a_fin_valid, fin_go, out_valid_q && (state_q == ST_IDLE))
endmodule

// File: sim/tb_multi_body_displacement_blend_top.sv
// Self-checking testbench for the multi-body displacement blend top level.
`timescale 1ns / 1ps
module tb_multi_body_displacement_blend_top;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 400;
	localparam longint unsigned RATIO_SUM_MAX = (64'd1 << 37) - 1;
	localparam longint VEC_SUM_MAX = (64'sd1 <<< 51) - 1;
	localparam longint VEC_SUM_MIN = -VEC_SUM_MAX - 1;

	typedef struct {
		logic [15:0]        w;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} body_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        far;
	} blend_t;

	typedef struct {
		body_t  b;
		bit     typed;
		blend_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [mbdb_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_ready, last_body;
	logic [15:0] body_weight;
	logic signed [31:0] disp_x, disp_y, disp_z;
	logic out_valid, out_ready;
	logic signed [31:0] out_x, out_y, out_z;
	logic [15:0] far_field_weight;

	multi_body_displacement_blend_top dut (.*);

	// Blend predictor state and configuration.
	longint unsigned offset_q = 1;
	longint unsigned ratio_acc = 65536;
	longint vec_acc [3] = '{0, 0, 0};
	int body_num = 0;

	blend_t pending_blends[$];
	row_t directed_rows[$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 0;

	// Clock.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Signed quotient of one vector sum by the ratio sum, toward zero, saturated.
	function automatic logic [31:0] blend_divide(input longint vs, input longint unsigned rs);
		longint unsigned mag, q, r, val;
		bit neg;
		neg = vs < 0;
		mag = neg ? longint'(-vs) : vs;
		q = mag / rs;
		r = mag % rs;
		val = (q << 16) + ((r << 16) / rs);
		if (neg) begin
			if (val > 64'h8000_0000)
				val = 64'h8000_0000;
			return 32'(64'd0 - val);
		end
		if (val > 64'h7FFF_FFFF)
			val = 64'h7FFF_FFFF;
		return 32'(val);
	endfunction

	// Adds one body to the point sums; returns 1 with the blend when the point closes.
	function automatic bit accumulate_body(input body_t b, output blend_t res);
		longint unsigned w64, ratio, far;
		longint d, term, s;
		logic signed [31:0] comp [3];
		comp = '{b.x, b.y, b.z};
		w64 = b.w;
		ratio = (w64 << 16) / (64'd65536 + offset_q - w64);
		ratio_acc += ratio;
		if (ratio_acc > RATIO_SUM_MAX)
			ratio_acc = RATIO_SUM_MAX;
		for (int c = 0; c < 3; c++) begin
			d = comp[c];
			term = (longint'(ratio) * d) >>> 16;
			s = vec_acc[c] + term;
			if (s > VEC_SUM_MAX)
				s = VEC_SUM_MAX;
			if (s < VEC_SUM_MIN)
				s = VEC_SUM_MIN;
			vec_acc[c] = s;
		end
		body_num++;
		if (!b.last && body_num < mbdb_pkg::MAX_BODIES_DEF)
			return 0;
		res.x = blend_divide(vec_acc[0], ratio_acc);
		res.y = blend_divide(vec_acc[1], ratio_acc);
		res.z = blend_divide(vec_acc[2], ratio_acc);
		far = (64'd1 << 32) / ratio_acc;
		res.far = (far > 64'hFFFF) ? 16'hFFFF : 16'(far);
		ratio_acc = 65536;
		vec_acc = '{0, 0, 0};
		body_num = 0;
		return 1;
	endfunction

	// Sends one item; a typed expectation replaces the predicted one.
	task automatic send_body(input body_t b, input bit typed, input blend_t typed_res);
		blend_t res;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 20) begin
			in_valid = 0;
			@(negedge clk);
		end
		body_weight = b.w;
		disp_x = b.x;
		disp_y = b.y;
		disp_z = b.z;
		last_body = b.last;
		in_valid = 1;
		do
			@(posedge clk);
		while (!in_ready);
		if (accumulate_body(b, res))
			pending_blends.push_back(typed ? typed_res : res);
	endtask

	task automatic apb_write(input logic [mbdb_pkg::PADDR_W-1:0] a, input logic [31:0] d);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1;
		do
			@(posedge clk);
		while (!pready);
		if (a == mbdb_pkg::ADDR_SMALL_OFFSET)
			offset_q = d[7:0];
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic apb_check(input logic [mbdb_pkg::PADDR_W-1:0] a, input logic [31:0] want);
		@(negedge clk);
		psel = 1;
		pwrite = 0;
		paddr = a;
		@(negedge clk);
		penable = 1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[7:0] !== want[7:0])
			report_mismatch("small_offset readback", prdata, want);
		@(negedge clk);
		psel = 0;
		penable = 0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 0;
		while (pending_blends.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_disp();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(131072)) - 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'hFFFF - 16'($urandom_range(300));
			3: return 16'($urandom_range(300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_row(input logic [15:0] w, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic last,
			input bit typed, input blend_t res);
		row_t r;
		r.b = '{w, x, y, z, last};
		r.typed = typed;
		r.res = res;
		directed_rows.push_back(r);
	endfunction

	// Result checker.
	always @(posedge clk) begin
		blend_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_blends.size() == 0) begin
				report_mismatch("unexpected result", out_x, 0);
			end else begin
				e = pending_blends.pop_front();
				if (out_x !== e.x)
					report_mismatch("out_x", out_x, e.x);
				if (out_y !== e.y)
					report_mismatch("out_y", out_y, e.y);
				if (out_z !== e.z)
					report_mismatch("out_z", out_z, e.z);
				if (far_field_weight !== e.far)
					report_mismatch("far_field_weight", far_field_weight, e.far);
			end
		end
	end

	// Receiver stalls.
	always @(negedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= 20);

	initial begin
		blend_t none, zero_far;
		body_t b;
		int sent, n;
		logic [7:0] offsets [6];
		none = '{0, 0, 0, 0};
		zero_far = '{0, 0, 0, 16'hFFFF};
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_valid = 0;
		body_weight = '0;
		disp_x = '0;
		disp_y = '0;
		disp_z = '0;
		last_body = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed table at the reset offset.
		apb_check(mbdb_pkg::ADDR_SMALL_OFFSET, {24'h0, mbdb_pkg::SMALL_OFFSET_RST});
		add_row(16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, zero_far);
		add_row(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1, 0, none);
		add_row(16'd1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1, 0, none);
		add_row(16'hFFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1, 0, none);
		add_row(16'h8000, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 0, 0, none);
		add_row(16'h4000, 32'hFFFF_0000, 32'h0003_0000, 32'hEDCB_A988, 1, 0, none);
		// A point with no last flag closes itself at the body limit.
		for (int i = 0; i < mbdb_pkg::MAX_BODIES_DEF; i++)
			add_row(16'd0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 0,
				i == mbdb_pkg::MAX_BODIES_DEF - 1, zero_far);
		add_row(16'h0001, 32'h0, 32'h0, 32'h0, 1, 0, none);
		foreach (directed_rows[i])
			send_body(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
		wait_drained();

		// Random phases over several offsets, extremes first.
		offsets = '{8'd0, 8'd255, 8'd1, 8'($urandom), 8'($urandom), 8'($urandom)};
		for (int p = 0; p < 6; p++) begin
			apb_write(mbdb_pkg::ADDR_SMALL_OFFSET, {24'h0, offsets[p]});
			apb_check(mbdb_pkg::ADDR_SMALL_OFFSET, {24'h0, offsets[p]});
			no_idle = (p == 2);
			sent = 0;
			while (sent < 210) begin
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++) begin
					b.w = rand_weight();
					b.x = rand_disp();
					b.y = rand_disp();
					b.z = rand_disp();
					// Mostly well-formed points, some with a stray flag.
					if ($urandom_range(9) == 0)
						b.last = $urandom_range(1);
					else
						b.last = (i == n - 1);
					send_body(b, 0, none);
					sent++;
				end
			end
			// Close any open point before the offset changes.
			b = '{rand_weight(), rand_disp(), rand_disp(), rand_disp(), 1'b1};
			send_body(b, 0, none);
			no_idle = 0;
			wait_drained();
		end

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
